// ===== design/wavelet_detail_shrink_recombine_macros.svh =====
// Assertion macros shared by the checker.
`ifndef WAVELET_DETAIL_SHRINK_RECOMBINE_MACROS_SVH
`define WAVELET_DETAIL_SHRINK_RECOMBINE_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define WDSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define WDSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/wdsr_pkg.sv =====
package wdsr_pkg;

    localparam int CFG_BITS     = 15;
    localparam int FRAC_BITS    = 12;
    // stages of a lane besides the divider: abs, square, den/num, amount, gain, sum
    localparam int FIXED_STAGES = 6;

    typedef logic [CFG_BITS-1:0] t_cfg;

    localparam t_cfg BOOST_RESET = t_cfg'(4096);

endpackage

// ===== design/wdsr_lane.sv =====
module wdsr_lane import wdsr_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [SAMPLE_BITS-1:0] i_coarse,
    input  logic signed [SAMPLE_BITS-1:0] i_detail,
    input  t_cfg                          i_thr,
    input  t_cfg                          i_boost,
    output logic signed [SAMPLE_BITS-1:0] o_result
);

    localparam int SB  = SAMPLE_BITS;
    localparam int TXW = CFG_BITS + 1;
    localparam int T2W = 2 * TXW;
    localparam int M2W = 2 * SB;
    localparam int DW  = ((M2W > T2W) ? M2W : T2W) + 1;
    localparam int NW  = SB + T2W;
    localparam int GW  = SB + CFG_BITS;
    localparam int SW  = SB + 5;
    localparam int L   = SB - 1;
    localparam logic signed [SW-1:0] MAXV = SW'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

    logic [SB-1:0] w_d;
    logic [SB-1:0] w_mag;

    // stage 0: magnitude and doubled threshold
    logic                 r_s0_neg;
    logic [SB-1:0]        r_s0_mag;
    logic [TXW-1:0]       r_s0_t2x;
    logic signed [SB-1:0] r_s0_c;
    // stage 1: squares
    logic                 r_s1_neg;
    logic [SB-1:0]        r_s1_mag;
    logic [M2W-1:0]       r_s1_mag2;
    logic [T2W-1:0]       r_s1_t2;
    logic signed [SB-1:0] r_s1_c;
    // stage 2: denominator and numerator
    logic                 r_s2_neg;
    logic [SB-1:0]        r_s2_mag;
    logic [DW-1:0]        r_s2_den;
    logic [NW-1:0]        r_s2_num;
    logic signed [SB-1:0] r_s2_c;
    // divider, one quotient bit per stage
    logic [DW-1:0]        r_rem   [SB];
    logic [SB-1:0]        r_q     [SB];
    logic [SB-1:0]        r_low   [SB];
    logic [DW-1:0]        r_den   [SB];
    logic [SB-1:0]        r_mag   [SB];
    logic                 r_neg   [SB];
    logic signed [SB-1:0] r_c     [SB];
    logic [DW-1:0]        n_rem   [SB];
    logic [SB-1:0]        n_q     [SB];
    // amount, gain, result
    logic [SB-1:0]        r_amt;
    logic                 r_a_neg;
    logic signed [SB-1:0] r_a_c;
    logic [GW-1:0]        r_gain;
    logic                 r_g_neg;
    logic signed [SB-1:0] r_g_c;
    logic signed [SB-1:0] r_out;

    logic [SB-1:0]        n_amt;
    logic signed [SW-1:0] w_cx;
    logic signed [SW-1:0] w_gx;
    logic signed [SW-1:0] w_sum;
    logic signed [SB-1:0] n_out;

    assign w_d   = i_detail;
    assign w_mag = w_d[SB-1] ? SB'(~w_d + 1'b1) : w_d;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0_neg  <= w_d[SB-1];
            r_s0_mag  <= w_mag;
            r_s0_t2x  <= {i_thr, 1'b0};
            r_s0_c    <= i_coarse;
            r_s1_neg  <= r_s0_neg;
            r_s1_mag  <= r_s0_mag;
            r_s1_mag2 <= M2W'(r_s0_mag) * M2W'(r_s0_mag);
            r_s1_t2   <= T2W'(r_s0_t2x) * T2W'(r_s0_t2x);
            r_s1_c    <= r_s0_c;
            r_s2_neg  <= r_s1_neg;
            r_s2_mag  <= r_s1_mag;
            r_s2_den  <= DW'(r_s1_mag2) + DW'(r_s1_t2);
            r_s2_num  <= NW'(r_s1_mag) * NW'(r_s1_t2);
            r_s2_c    <= r_s1_c;
        end
    end

    // Restoring divide of mag*T2 by den. The quotient never exceeds mag, so
    // the top part of the numerator already sits below den.
    always_comb begin
        logic [DW-1:0] rem_in;
        logic [SB-1:0] q_in;
        logic [SB-1:0] low_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   trial;
        for (int k = 0; k < SB; k++) begin
            if (k == 0) begin
                rem_in = DW'(r_s2_num[NW-1:SB]);
                q_in   = '0;
                low_in = r_s2_num[SB-1:0];
                den_in = r_s2_den;
            end else begin
                rem_in = r_rem[k-1];
                q_in   = r_q[k-1];
                low_in = r_low[k-1];
                den_in = r_den[k-1];
            end
            trial = {rem_in, low_in[SB-1-k]};
            if (trial >= (DW+1)'(den_in)) begin
                n_rem[k] = DW'(trial - (DW+1)'(den_in));
                n_q[k]   = {q_in[SB-2:0], 1'b1};
            end else begin
                n_rem[k] = DW'(trial);
                n_q[k]   = {q_in[SB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SB; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                if (k == 0) begin
                    r_low[k] <= r_s2_num[SB-1:0];
                    r_den[k] <= r_s2_den;
                    r_mag[k] <= r_s2_mag;
                    r_neg[k] <= r_s2_neg;
                    r_c[k]   <= r_s2_c;
                end else begin
                    r_low[k] <= r_low[k-1];
                    r_den[k] <= r_den[k-1];
                    r_mag[k] <= r_mag[k-1];
                    r_neg[k] <= r_neg[k-1];
                    r_c[k]   <= r_c[k-1];
                end
            end
        end
    end

    // amount = mag - ceil(mag*T2/den); zero denominator gives zero
    always_comb begin
        if (r_den[L] == '0) begin
            n_amt = '0;
        end else begin
            n_amt = SB'(r_mag[L] - r_q[L] - SB'(r_rem[L] != '0));
        end
    end

    assign w_cx  = SW'(r_g_c);
    assign w_gx  = signed'(SW'(r_gain >> FRAC_BITS));
    assign w_sum = r_g_neg ? (w_cx - w_gx) : (w_cx + w_gx);

    always_comb begin
        if (w_sum > MAXV) begin
            n_out = SB'(MAXV);
        end else if (w_sum < MINV) begin
            n_out = SB'(MINV);
        end else begin
            n_out = SB'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_amt   <= n_amt;
            r_a_neg <= r_neg[L];
            r_a_c   <= r_c[L];
            r_gain  <= GW'(r_amt) * GW'(i_boost);
            r_g_neg <= r_a_neg;
            r_g_c   <= r_a_c;
            r_out   <= n_out;
        end
    end

    assign o_result = r_out;

endmodule

// ===== design/wavelet_detail_shrink_recombine.sv =====
// Wavelet detail shrink and recombine: per channel, result = coarse + boost * d^3 / (d^2 +
// (2*threshold)^2), signed Q3.12 samples, saturated. One pixel item is taken every cycle
// unless the output is held, and back-pressure on the output stalls the whole pipeline
// without losing items. Thresholds and boosts are to be written through the config port
// while no items are in flight; the block does not enforce this, the user must.
module wavelet_detail_shrink_recombine import wdsr_pkg::*; #(
    parameter int CHANNELS    = 4,
    parameter int SAMPLE_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // coarse_ch0..N-1, then detail_ch0..N-1, zero padded to bytes
    input  logic [((2*CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // result_ch0..N-1, zero padded to bytes
    output logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0]   m_axis_tdata,
    input  logic i_cfg_we,
    input  logic [((2*CHANNELS > 2) ? $clog2(2*CHANNELS) : 1)-1:0] i_cfg_idx,
    input  t_cfg i_cfg_data
);

    localparam int SB  = SAMPLE_BITS;
    localparam int IW  = (2*CHANNELS > 2) ? $clog2(2*CHANNELS) : 1;
    localparam int LAT = SB + FIXED_STAGES;
    localparam int OW  = ((CHANNELS*SB+7)/8)*8;

    t_cfg          r_thr   [CHANNELS];
    t_cfg          r_boost [CHANNELS];
    logic [LAT-1:0] r_vld;
    logic          w_en;
    logic [CHANNELS*SB-1:0] w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r_thr[ch]   <= '0;
                r_boost[ch] <= BOOST_RESET;
            end
        end else if (i_cfg_we) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                if (i_cfg_idx == IW'(ch)) begin
                    r_thr[ch] <= i_cfg_data;
                end
                if (i_cfg_idx == IW'(ch + CHANNELS)) begin
                    r_boost[ch] <= i_cfg_data;
                end
            end
        end
    end

    // advance everything unless the output item is held
    assign w_en = !r_vld[LAT-1] || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
        wdsr_lane #(
            .SAMPLE_BITS (SB)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_coarse (s_axis_tdata[ch*SB +: SB]),
            .i_detail (s_axis_tdata[(CHANNELS+ch)*SB +: SB]),
            .i_thr    (r_thr[ch]),
            .i_boost  (r_boost[ch]),
            .o_result (w_res[ch*SB +: SB])
        );
    end

    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAT-1];
    assign m_axis_tdata  = OW'(w_res);

endmodule

// ===== design/wdsr_checker.sv =====
`include "wavelet_detail_shrink_recombine_macros.svh"

module wdsr_checker import wdsr_pkg::*; #(
    parameter int CHANNELS    = 4,
    parameter int SAMPLE_BITS = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);

    // a held output item keeps its valid and its data
    `WDSR_ASSERT_NEXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output item dropped under stall")
    `WDSR_ASSERT_NEXT(a_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "output item changed under stall")
    // input side opens exactly when the output stage can move
    `WDSR_ASSERT_NOW(a_ready, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready out of step with output stage")
    // nothing emerges right after reset
    `WDSR_ASSERT_NOW(a_reset_empty, $past(!i_rst_n), !m_axis_tvalid, "output item right after reset")

endmodule

bind wavelet_detail_shrink_recombine wdsr_checker #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_wdsr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import wdsr_pkg::*;

    localparam int NCH   = 4;
    localparam int SBITS = 16;
    localparam int LATENCY = SBITS + FIXED_STAGES;

    // register indexes on the config port
    localparam logic [2:0] REG_THR0   = 3'd0;
    localparam logic [2:0] REG_BOOST0 = 3'd4;

    typedef struct {
        logic [127:0] px;
        bit           known;
        logic [63:0]  want;
    } t_dir_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // coarse_ch0..3, detail_ch0..3
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // result_ch0..3
    logic [63:0]  m_axis_tdata;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_idx;
    t_cfg         i_cfg_data;

    t_cfg        thr_m   [NCH];
    t_cfg        boost_m [NCH];
    logic [63:0] pixel_q [$];
    t_dir_row    dir_rows[$];
    int          err_cnt;
    bit          hold_out;
    bit          no_gaps;

    wavelet_detail_shrink_recombine u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [15:0] shrink_lane(logic [15:0] c_bits, logic [15:0] d_bits,
                                                 t_cfg thr, t_cfg boost);
        longint c, d, mag, t2, den, num, cut, amt, gain, sum;
        c   = longint'($signed(c_bits));
        d   = longint'($signed(d_bits));
        mag = (d < 0) ? -d : d;
        t2  = (2 * longint'(thr)) * (2 * longint'(thr));
        den = mag * mag + t2;
        amt = 0;
        if (den != 0) begin
            num = mag * t2;
            cut = num / den + ((num % den) != 0 ? 1 : 0);
            amt = mag - cut;
        end
        gain = (amt * longint'(boost)) >>> FRAC_BITS;
        sum  = (d < 0) ? c - gain : c + gain;
        if (sum > 32767) sum = 32767;
        if (sum < -32768) sum = -32768;
        return sum[15:0];
    endfunction

    function automatic logic [63:0] recombine_pixel(logic [127:0] px);
        logic [63:0] r;
        for (int ch = 0; ch < NCH; ch++) begin
            r[ch*16 +: 16] = shrink_lane(px[ch*16 +: 16], px[64 + ch*16 +: 16],
                                         thr_m[ch], boost_m[ch]);
        end
        return r;
    endfunction

    function automatic logic [127:0] same_px(logic [15:0] c, logic [15:0] d);
        return {{NCH{d}}, {NCH{c}}};
    endfunction

    function automatic logic [15:0] pick_detail(t_cfg thr);
        int mode;
        mode = $urandom_range(0, 4);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 1023)) - 512);
            2: return 16'(int'(thr) * ($urandom_range(0, 1) ? 1 : -1)
                          + $signed($urandom_range(0, 64)) - 32);
            3: begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    3: return 16'h0001;
                    default: return 16'hffff;
                endcase
            end
            default: return 16'(2 * int'(thr) + $urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [127:0] random_px();
        logic [127:0] px;
        for (int ch = 0; ch < NCH; ch++) begin
            px[ch*16 +: 16] = ($urandom_range(0, 7) == 0) ?
                              ($urandom_range(0, 1) ? 16'h7fff : 16'h8000) : 16'($urandom);
            px[64 + ch*16 +: 16] = pick_detail(thr_m[ch]);
        end
        return px;
    endfunction

    // hold every register write; indexes run back to back without lowering the enable
    task automatic load_regs(t_cfg thr[NCH], t_cfg boost[NCH]);
        for (int i = 0; i < 2 * NCH; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= (i < NCH) ? REG_THR0 + 3'(i) : REG_BOOST0 + 3'(i - NCH);
            i_cfg_data <= (i < NCH) ? thr[i] : boost[i - NCH];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        thr_m   = thr;
        boost_m = boost;
    endtask

    task automatic drain_wait();
        wait (pixel_q.size() == 0);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic send_px(logic [127:0] px, bit known, logic [63:0] want);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        pixel_q.push_back(known ? want : recombine_pixel(px));
    endtask

    task automatic run_random(int n);
        for (int k = 0; k < n; k++) send_px(random_px(), 1'b0, '0);
        s_axis_tvalid <= 1'b0;
    endtask

    // receiver: random stalls, with an optional long hold-off
    initial begin
        int w;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_out) begin
                m_axis_tready <= 1'b0;
                for (int n = 0; n < 400; n++) @(posedge i_clk);
                hold_out = 1'b0;
            end
            w = no_gaps ? 0 : $urandom_range(0, 17);
            if (w > 0) begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // result checker
    initial begin
        logic [63:0] want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (pixel_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                    err_cnt++;
                end else begin
                    want = pixel_q.pop_front();
                    for (int ch = 0; ch < NCH; ch++) begin
                        if (m_axis_tdata[ch*16 +: 16] !== want[ch*16 +: 16]) begin
                            $display("%0t: result_ch%0d expected %h actual %h", $time, ch,
                                     want[ch*16 +: 16], m_axis_tdata[ch*16 +: 16]);
                            err_cnt++;
                        end
                    end
                end
            end
        end
    end

    initial begin
        t_cfg thr[NCH];
        t_cfg boost[NCH];
        int   cnt;
        err_cnt       = 0;
        hold_out      = 1'b0;
        no_gaps       = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        for (int ch = 0; ch < NCH; ch++) begin
            thr_m[ch]   = '0;
            boost_m[ch] = BOOST_RESET;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: zero threshold, unity boost, so result = sat(coarse + detail)
        dir_rows.push_back('{same_px(16'h0000, 16'h0000), 1'b1, {4{16'h0000}}});
        dir_rows.push_back('{same_px(16'd1234, 16'h0000), 1'b1, {4{16'd1234}}});
        dir_rows.push_back('{same_px(16'd1000, 16'd2000), 1'b1, {4{16'd3000}}});
        dir_rows.push_back('{same_px(16'd100, -16'sd200), 1'b1, {4{-16'sd100}}});
        dir_rows.push_back('{same_px(16'h7fff, 16'h0001), 1'b1, {4{16'h7fff}}});
        dir_rows.push_back('{same_px(16'h8000, 16'hffff), 1'b1, {4{16'h8000}}});
        dir_rows.push_back('{same_px(16'h7fff, 16'h7fff), 1'b1, {4{16'h7fff}}});
        dir_rows.push_back('{same_px(16'h8000, 16'h8000), 1'b1, {4{16'h8000}}});
        dir_rows.push_back('{same_px(16'h0000, 16'h8000), 1'b1, {4{16'h8000}}});
        dir_rows.push_back('{same_px(16'h8000, 16'h7fff), 1'b1, {4{16'hffff}}});
        dir_rows.push_back('{{16'h8000, 16'h7fff, 16'h0001, 16'h0000,
                              16'h7fff, 16'h8000, 16'h0000, 16'h0005}, 1'b0, '0});
        dir_rows.push_back('{{16'h1234, 16'hedcb, 16'h0800, 16'hf800,
                              16'h4000, 16'hc000, 16'h2000, 16'he000}, 1'b0, '0});
        foreach (dir_rows[i]) send_px(dir_rows[i].px, dir_rows[i].known, dir_rows[i].want);
        s_axis_tvalid <= 1'b0;
        drain_wait();

        // largest threshold and boost: shrink hard, gain near 8x
        for (int ch = 0; ch < NCH; ch++) begin thr[ch] = 15'h7fff; boost[ch] = 15'h7fff; end
        load_regs(thr, boost);
        dir_rows.delete();
        dir_rows.push_back('{same_px(16'h7fff, 16'h7fff), 1'b0, '0});
        dir_rows.push_back('{same_px(16'h8000, 16'h8000), 1'b0, '0});
        dir_rows.push_back('{same_px(16'h0000, 16'h0001), 1'b0, '0});
        dir_rows.push_back('{same_px(16'h0000, 16'h0000), 1'b0, '0});
        foreach (dir_rows[i]) send_px(dir_rows[i].px, 1'b0, '0);
        run_random(150);
        drain_wait();

        // zero boost: result = coarse; zero threshold with max gain saturates often
        for (int ch = 0; ch < NCH; ch++) begin
            thr[ch]   = (ch < 2) ? 15'h7fff : 15'h0000;
            boost[ch] = (ch[0]) ? 15'h7fff : 15'h0000;
        end
        load_regs(thr, boost);
        send_px(same_px(16'h7fff, 16'h8000), 1'b0, '0);
        run_random(150);
        drain_wait();

        // back-to-back with a long output hold-off to fill the pipeline
        for (int ch = 0; ch < NCH; ch++) begin
            thr[ch] = 15'($urandom_range(0, 4095)); boost[ch] = 15'($urandom);
        end
        load_regs(thr, boost);
        no_gaps  = 1'b1;
        hold_out = 1'b1;
        run_random(200);
        no_gaps  = 1'b0;
        drain_wait();

        cnt = 0;
        while (cnt < 950) begin
            for (int ch = 0; ch < NCH; ch++) begin
                thr[ch]   = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                        : 15'($urandom_range(0, 2047));
                boost[ch] = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                        : 15'($urandom_range(0, 8191));
            end
            load_regs(thr, boost);
            no_gaps = ($urandom_range(0, 3) == 0);
            run_random(190);
            no_gaps = 1'b0;
            cnt += 190;
            drain_wait();
        end

        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/wdsr_pkg.sv
design/wdsr_lane.sv
design/wavelet_detail_shrink_recombine.sv
design/wdsr_checker.sv
tb/tb.sv
